// File: sv/llft_pkg.sv
// Shared types and constants for the lattice link fracture test.
// No dependencies.
package llft_pkg;

  // Configuration register indexes
  localparam logic [2:0] CfgFractureEn = 3'd0;
  localparam logic [2:0] CfgDistEn     = 3'd1;
  localparam logic [2:0] CfgDistTol    = 3'd2;
  localparam logic [2:0] CfgRotEn      = 3'd3;
  localparam logic [2:0] CfgRotTol     = 3'd4;
  localparam logic [2:0] CfgGoalWeight = 3'd5;

  localparam logic [15:0] WeightOne = 16'h8000;
  localparam int RotTolShift = 3;   // Q5.11 tolerance to 14 fraction bits

  typedef enum logic [1:0] {
    CAUSE_NONE = 2'd0,
    CAUSE_DIST = 2'd1,
    CAUSE_ROT  = 2'd2
  } cause_e;

  typedef struct packed {
    logic        fracture_en;
    logic        dist_en;
    logic [15:0] dist_tol;
    logic        rot_en;
    logic [15:0] rot_tol;
    logic [15:0] goal_weight;
  } cfg_t;

endpackage

// File: sv/llft_fifo.sv
// Two-entry queue used between front and back and at the result side.
// Depends on nothing.
module llft_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);
  logic [Width-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end
endmodule

// File: sv/llft_front.sv
// Front part: unpacks components, forms squared lengths and the rotation check.
// Depends on llft_pkg.
module llft_front import llft_pkg::*; #(
  parameter int CB = 16
) (
  input  logic [3*CB-1:0]   rest_pos_a_i,
  input  logic [3*CB-1:0]   rest_pos_b_i,
  input  logic [3*CB-1:0]   goal_pos_a_i,
  input  logic [3*CB-1:0]   goal_pos_b_i,
  input  logic [3*CB-1:0]   cur_pos_a_i,
  input  logic [3*CB-1:0]   cur_pos_b_i,
  input  logic [9*CB-1:0]   rot_a_i,
  input  logic [9*CB-1:0]   rot_b_i,
  input  cfg_t              cfg_i,
  output logic [2*CB+1:0]   sq_n_o,
  output logic [2*CB+1:0]   sq_g_o,
  output logic [2*CB+1:0]   sq_c_o,
  output logic              rot_bad_o
);
  localparam int SQS = 2 * CB + 2;
  localparam int RSW = CB + 4;
  localparam int CW  = (RSW > 16 + RotTolShift) ? RSW : 16 + RotTolShift;

  // absolute difference of two signed components
  function automatic logic [CB-1:0] absd(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic signed [CB:0] d;
    d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
    absd = d[CB] ? CB'(-d) : d[CB-1:0];
  endfunction

  function automatic logic [SQS-1:0] sqlen(input logic [3*CB-1:0] p, input logic [3*CB-1:0] q);
    logic [CB-1:0]   d;
    logic [SQS-1:0]  s;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      d = absd(p[k*CB +: CB], q[k*CB +: CB]);
      s = s + SQS'(d) * SQS'(d);
    end
    sqlen = s;
  endfunction

  assign sq_n_o = sqlen(rest_pos_a_i, rest_pos_b_i);
  assign sq_g_o = sqlen(goal_pos_a_i, goal_pos_b_i);
  assign sq_c_o = sqlen(cur_pos_a_i, cur_pos_b_i);

  // summed absolute rotation differences against the tolerance
  logic [RSW-1:0] rsum;
  always_comb begin
    rsum = '0;
    for (int e = 0; e < 9; e++) begin
      rsum = rsum + RSW'(absd(rot_a_i[e*CB +: CB], rot_b_i[e*CB +: CB]));
    end
  end

  assign rot_bad_o = CW'(rsum) > CW'({cfg_i.rot_tol, 3'b000});
endmodule

// File: sv/llft_back.sv
// Back part: pipelined square roots, blend, tolerance compare and cause.
// Depends on llft_pkg.
module llft_back import llft_pkg::*; #(
  parameter int CB = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              q_empty_i,
  input  logic [6*CB+6:0]   q_data_i,
  output logic              q_pop_o,
  input  logic              out_full_i,
  output logic              out_push_o,
  output logic [1:0]        out_cause_o
);
  localparam int SQS = 2 * CB + 2;
  localparam int RW  = CB + 9;           // root width
  localparam int XW  = 2 * RW;           // padded radicand width
  localparam int BW  = RW + 19;          // blend/limit width

  logic adv;
  assign adv     = !out_full_i;
  assign q_pop_o = adv && !q_empty_i;

  // sqrt pipeline: stage s holds radicand, remainder and partial root
  logic [RW:0]     vld_q;
  logic [XW-1:0]   x_q    [RW+1][3];
  logic [RW+1:0]   rem_q  [RW+1][3];
  logic [RW-1:0]   root_q [RW+1][3];
  logic            rot_q  [RW+1];

  logic [XW-1:0]   x_d    [RW+1][3];
  logic [RW+1:0]   rem_d  [RW+1][3];
  logic [RW-1:0]   root_d [RW+1][3];
  logic            rot_d  [RW+1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      x_d[0][l]    = {q_data_i[l*SQS +: SQS], 16'h0000};
      rem_d[0][l]  = '0;
      root_d[0][l] = '0;
    end
    rot_d[0] = q_data_i[3*SQS];
  end

  for (genvar s = 0; s < RW; s++) begin : g_sqrt
    always_comb begin
      logic [RW+1:0] r2, t;
      for (int l = 0; l < 3; l++) begin
        r2 = {rem_q[s][l][RW-1:0], x_q[s][l][2*(RW-1-s) +: 2]};
        t  = {root_q[s][l], 2'b01};
        x_d[s+1][l] = x_q[s][l];
        if (r2 >= t) begin
          rem_d[s+1][l]  = r2 - t;
          root_d[s+1][l] = {root_q[s][l][RW-2:0], 1'b1};
        end else begin
          rem_d[s+1][l]  = r2;
          root_d[s+1][l] = {root_q[s][l][RW-2:0], 1'b0};
        end
      end
      rot_d[s+1] = rot_q[s];
    end
  end

  // blend and limit stage, then compare stage
  logic            vb_q, vc_q;
  logic [BW-1:0]   bl_q, ns_q, lim_q;
  logic            rotb_q;
  logic [1:0]      cause_q, cause_d;
  logic [15:0]     w_sat;
  logic [BW-1:0]   bl_d, ns_d, lim_d, diff;
  logic            dist_bad;

  assign w_sat = (cfg_i.goal_weight > WeightOne) ? WeightOne : cfg_i.goal_weight;

  always_comb begin
    bl_d  = BW'(root_q[RW][1]) * BW'(w_sat) +
            BW'(root_q[RW][2]) * BW'(WeightOne - w_sat);
    ns_d  = BW'({root_q[RW][0], 15'h0000});
    lim_d = (BW'(cfg_i.dist_tol) * BW'(root_q[RW][0])) << 3;
  end

  always_comb begin
    diff     = (ns_q >= bl_q) ? ns_q - bl_q : bl_q - ns_q;
    dist_bad = diff > lim_q;
    cause_d  = CAUSE_NONE;
    if (cfg_i.fracture_en) begin
      if (cfg_i.dist_en && dist_bad) cause_d = CAUSE_DIST;
      else if (cfg_i.rot_en && rotb_q) cause_d = CAUSE_ROT;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vb_q  <= 1'b0;
      vc_q  <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[RW-1:0], !q_empty_i};
      vb_q  <= vld_q[RW];
      vc_q  <= vb_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s <= RW; s++) begin
        for (int l = 0; l < 3; l++) begin
          x_q[s][l]    <= x_d[s][l];
          rem_q[s][l]  <= rem_d[s][l];
          root_q[s][l] <= root_d[s][l];
        end
        rot_q[s] <= rot_d[s];
      end
      bl_q    <= bl_d;
      ns_q    <= ns_d;
      lim_q   <= lim_d;
      rotb_q  <= rot_q[RW];
      cause_q <= cause_d;
    end
  end

  assign out_push_o  = vc_q && adv;
  assign out_cause_o = cause_q;
endmodule

// File: sv/lattice_link_fracture_test.sv
// Top level of the lattice link fracture test: config registers, front, queues, back.
// Depends on llft_pkg, llft_front, llft_fifo, llft_back.
//
//   channel   handshake        payload
//   input     push / full      positions and rotation rows
//   result    empty / pop      link_broken_o, break_cause_o
//   config    cfg_we_i         cfg_index_i, cfg_wdata_i
//
// One item per cycle sustained while the result queue has room. Items pass from push
// to result through the one-bit-per-stage square root pipeline.
// Reset clears queues, valid bits and config registers to their defaults.
// A full result queue stalls the whole back pipeline; the front queue then fills.
module lattice_link_fracture_test import llft_pkg::*; #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [15:0]                 cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic [3*COMPONENT_BITS-1:0] rest_pos_a_i,
  input  logic [3*COMPONENT_BITS-1:0] rest_pos_b_i,
  input  logic [3*COMPONENT_BITS-1:0] goal_pos_a_i,
  input  logic [3*COMPONENT_BITS-1:0] goal_pos_b_i,
  input  logic [3*COMPONENT_BITS-1:0] cur_pos_a_i,
  input  logic [3*COMPONENT_BITS-1:0] cur_pos_b_i,
  input  logic [3*COMPONENT_BITS-1:0] rot_a_row0_i,
  input  logic [3*COMPONENT_BITS-1:0] rot_a_row1_i,
  input  logic [3*COMPONENT_BITS-1:0] rot_a_row2_i,
  input  logic [3*COMPONENT_BITS-1:0] rot_b_row0_i,
  input  logic [3*COMPONENT_BITS-1:0] rot_b_row1_i,
  input  logic [3*COMPONENT_BITS-1:0] rot_b_row2_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        link_broken_o,
  output logic [1:0]                  break_cause_o
);
  localparam int CB  = COMPONENT_BITS;
  localparam int SQS = 2 * CB + 2;
  localparam int QW  = 3 * SQS + 1;

  // configuration registers
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fracture_en <= 1'b0;
      cfg_q.dist_en     <= 1'b1;
      cfg_q.dist_tol    <= 16'd1024;
      cfg_q.rot_en      <= 1'b1;
      cfg_q.rot_tol     <= 16'd2048;
      cfg_q.goal_weight <= 16'd16384;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFractureEn: cfg_q.fracture_en <= cfg_wdata_i[0];
        CfgDistEn:     cfg_q.dist_en     <= cfg_wdata_i[0];
        CfgDistTol:    cfg_q.dist_tol    <= cfg_wdata_i;
        CfgRotEn:      cfg_q.rot_en      <= cfg_wdata_i[0];
        CfgRotTol:     cfg_q.rot_tol     <= cfg_wdata_i;
        CfgGoalWeight: cfg_q.goal_weight <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front
  logic [SQS-1:0] sq_n, sq_g, sq_c;
  logic           rot_bad;
  llft_front #(.CB(CB)) u_front (
    .rest_pos_a_i, .rest_pos_b_i, .goal_pos_a_i, .goal_pos_b_i,
    .cur_pos_a_i, .cur_pos_b_i,
    .rot_a_i   ({rot_a_row2_i, rot_a_row1_i, rot_a_row0_i}),
    .rot_b_i   ({rot_b_row2_i, rot_b_row1_i, rot_b_row0_i}),
    .cfg_i     (cfg_q),
    .sq_n_o    (sq_n),
    .sq_g_o    (sq_g),
    .sq_c_o    (sq_c),
    .rot_bad_o (rot_bad)
  );

  // queue between front and back
  logic          q_pop, q_empty;
  logic [QW-1:0] q_data;
  llft_fifo #(.Width(QW)) u_mid_q (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  ({rot_bad, sq_c, sq_g, sq_n}),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  // back
  logic       out_full, out_push;
  logic [1:0] out_cause;
  llft_back #(.CB(CB)) u_back (
    .clk_i, .rst_ni,
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_cause_o (out_cause)
  );

  // result queue
  llft_fifo #(.Width(2)) u_out_q (
    .clk_i, .rst_ni,
    .push_i  (out_push),
    .data_i  (out_cause),
    .full_o  (out_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (break_cause_o)
  );

  assign link_broken_o = (break_cause_o != CAUSE_NONE);
endmodule

// File: sv/llft_checker.sv
// Port-level checks for the lattice link fracture test, bound to the top level.
// Depends on llft_pkg and lattice_link_fracture_test.
module llft_checker import llft_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       link_broken_o,
  input logic [1:0] break_cause_o
);
  // broken flag agrees with the cause
  a_broken_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (link_broken_o == (break_cause_o != CAUSE_NONE)))
    else $error("link_broken disagrees with break_cause");

  // no undefined cause code on a waiting item
  a_cause_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (break_cause_o == CAUSE_NONE || break_cause_o == CAUSE_DIST ||
                break_cause_o == CAUSE_ROT))
    else $error("undefined break cause");

  // a waiting item stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(break_cause_o)))
    else $error("waiting item changed or vanished");
endmodule

bind lattice_link_fracture_test llft_checker u_llft_checker (
  .clk_i, .rst_ni, .empty, .pop, .link_broken_o, .break_cause_o
);
